// ===== design/bhse_pkg.sv =====
// ----------------------------------------------------------------------------
// bhse_pkg
// Types and constants shared by the button hold setpoint editor modules.
// ----------------------------------------------------------------------------
package bhse_pkg;

   // Setpoint steps and saturation limits.
   localparam logic [14:0] V_STEP    = 15'd100;
   localparam logic [14:0] V_TOP     = 15'h7FFF;
   localparam logic [12:0] I_STEP    = 13'd20;
   localparam logic [12:0] I_TOP     = 13'h1FFF;
   localparam logic [2:0]  CNT_TOP   = 3'd7;

   // Reset values of the setpoints and the limit registers.
   localparam logic [14:0] V_RESET     = 15'd3300;
   localparam logic [12:0] I_RESET     = 13'd3000;
   localparam logic [14:0] MIN_V_RESET = 15'd3300;
   localparam logic [14:0] MAX_V_RESET = 15'd10000;
   localparam logic [12:0] MAX_I_RESET = 13'd3000;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MIN_VOLTAGE = 2'd0;
   localparam logic [1:0] CSR_MAX_VOLTAGE = 2'd1;
   localparam logic [1:0] CSR_MAX_CURRENT = 2'd2;

   // One poll tick of button levels.
   typedef struct packed {
      logic left_pressed;
      logic right_pressed;
      logic middle_pressed;
   } req_type;

   // One result: setpoints and mode bits after the tick.
   typedef struct packed {
      logic [14:0] voltage_setpoint_mv;
      logic [12:0] current_setpoint_ma;
      logic        edit_mode;
      logic        output_on;
   } rsp_type;

   // Limits held in the configuration registers.
   typedef struct packed {
      logic [14:0] min_voltage_mv;
      logic [14:0] max_voltage_mv;
      logic [12:0] max_current_ma;
   } cfg_type;

   // Editor state carried from tick to tick.
   typedef struct packed {
      logic [14:0] voltage;
      logic [12:0] current;
      logic        mode;
      logic        output_on;
      logic [2:0]  right_cnt;
      logic [2:0]  left_cnt;
      logic [2:0]  both_cnt;
      logic [2:0]  middle_cnt;
   } state_type;

endpackage

// ===== design/bhse_update.sv =====
// ----------------------------------------------------------------------------
// bhse_update
// Next-state logic for one poll tick: hold counters, setpoint steps and
// the mode and output toggles.
// ----------------------------------------------------------------------------
module bhse_update
   import bhse_pkg::*;
#(
   parameter int unsigned HOLD_TICKS = 5
) (
   input  state_type cur,
   input  cfg_type   cfg,
   input  req_type   req,
   output state_type nxt
);

   localparam logic [2:0] HOLD_CNT = 3'(HOLD_TICKS);

   // Saturating hold counter that clears on release.
   function automatic logic [2:0] count_tick(input logic [2:0] cnt, input logic pressed);
      logic [2:0] res;
      if (!pressed) begin
         res = 3'd0;
      end else if (cnt >= CNT_TOP) begin
         res = CNT_TOP;
      end else begin
         res = cnt + 3'd1;
      end
      return res;
   endfunction

   logic        right_hit;
   logic        left_hit;
   logic [15:0] v_up;
   logic [14:0] v_mid;
   logic [13:0] i_up;
   logic [12:0] i_mid;

   always_comb begin
      nxt = cur;

      // Button hold counters.
      nxt.right_cnt = count_tick(cur.right_cnt, req.right_pressed);
      nxt.left_cnt  = count_tick(cur.left_cnt, req.left_pressed);
      right_hit = req.right_pressed && (nxt.right_cnt > HOLD_CNT);
      left_hit  = req.left_pressed && (nxt.left_cnt > HOLD_CNT);

      // Voltage steps: up first, then down from the stepped value.
      v_up  = {1'b0, cur.voltage} + {1'b0, V_STEP};
      v_mid = cur.voltage;
      if (!cur.mode && right_hit && (cur.voltage < cfg.max_voltage_mv)) begin
         v_mid = v_up[15] ? V_TOP : v_up[14:0];
      end
      nxt.voltage = v_mid;
      if (!cur.mode && left_hit && (v_mid > cfg.min_voltage_mv)) begin
         nxt.voltage = (v_mid < V_STEP) ? 15'd0 : v_mid - V_STEP;
      end

      // Current steps, same order.
      i_up  = {1'b0, cur.current} + {1'b0, I_STEP};
      i_mid = cur.current;
      if (cur.mode && right_hit && (cur.current < cfg.max_current_ma)) begin
         i_mid = i_up[13] ? I_TOP : i_up[12:0];
      end
      nxt.current = i_mid;
      if (cur.mode && left_hit && (i_mid != 13'd0)) begin
         nxt.current = (i_mid < I_STEP) ? 13'd0 : i_mid - I_STEP;
      end

      // Both buttons held toggles the edit mode.
      nxt.both_cnt = count_tick(cur.both_cnt, req.left_pressed && req.right_pressed);
      if (nxt.both_cnt > HOLD_CNT) begin
         nxt.mode     = ~cur.mode;
         nxt.both_cnt = 3'd0;
      end

      // Middle button held toggles the output enable.
      nxt.middle_cnt = count_tick(cur.middle_cnt, req.middle_pressed);
      if (nxt.middle_cnt > HOLD_CNT) begin
         nxt.output_on  = ~cur.output_on;
         nxt.middle_cnt = 3'd0;
      end
   end

endmodule

// ===== design/button_hold_setpoint_editor_unit.sv =====
// ----------------------------------------------------------------------------
// button_hold_setpoint_editor_unit
// Button hold editor for voltage and current setpoints with mode and output
// toggles, one poll tick per transfer.
// ----------------------------------------------------------------------------
// Flow: a request is taken into the input register and its result then into the
// result register; a held result stalls the input register behind it.
// Throughput: one tick per cycle while no result is stalled; the state update is a single registered
// pass between the input register and the result register.
// Reset: synchronous; clears setpoints to 3300 mV and 3000 mA, voltage mode,
// output off, all hold counters and the limit registers to their defaults.
module button_hold_setpoint_editor_unit
   import bhse_pkg::*;
#(
   parameter int unsigned HOLD_TICKS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata
);

   logic      s1_valid_ff, s1_valid_in;
   req_type   s1_data_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff;
   state_type state_ff, state_in;
   cfg_type   cfg_ff, cfg_in;
   logic      advance;
   logic      req_take;

   // Pipeline control: the input stage moves on when the result slot frees.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   // Tick update logic.
   bhse_update #(
      .HOLD_TICKS(HOLD_TICKS)
   ) u_update (
      .cur(state_ff),
      .cfg(cfg_ff),
      .req(s1_data_ff),
      .nxt(state_in)
   );

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MIN_VOLTAGE: cfg_in.min_voltage_mv = csr_wdata;
            CSR_MAX_VOLTAGE: cfg_in.max_voltage_mv = csr_wdata;
            CSR_MAX_CURRENT: cfg_in.max_current_ma = csr_wdata[12:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         cfg_ff.min_voltage_mv <= MIN_V_RESET;
         cfg_ff.max_voltage_mv <= MAX_V_RESET;
         cfg_ff.max_current_ma <= MAX_I_RESET;
         state_ff.voltage      <= V_RESET;
         state_ff.current      <= I_RESET;
         state_ff.mode         <= 1'b0;
         state_ff.output_on    <= 1'b0;
         state_ff.right_cnt    <= 3'd0;
         state_ff.left_cnt     <= 3'd0;
         state_ff.both_cnt     <= 3'd0;
         state_ff.middle_cnt   <= 3'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff.voltage_setpoint_mv <= state_in.voltage;
         rsp_data_ff.current_setpoint_ma <= state_in.current;
         rsp_data_ff.edit_mode           <= state_in.mode;
         rsp_data_ff.output_on           <= state_in.output_on;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // The input side only stalls while a result is held back.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a blocked result");

   // Setpoints change only on a tick that moves into the result register.
   a_setpoint_hold: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(advance)) |->
         ($stable(state_ff.voltage) && $stable(state_ff.current)))
      else $error("setpoint changed without a tick");

   // Mode and output toggles happen only on a tick.
   a_toggle_hold: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(advance)) |->
         ($stable(state_ff.mode) && $stable(state_ff.output_on)))
      else $error("mode or output changed without a tick");

   // Toggle counters clear once they pass the threshold.
   a_toggle_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff.both_cnt <= 3'(HOLD_TICKS)) && (state_ff.middle_cnt <= 3'(HOLD_TICKS)))
      else $error("toggle hold counter above threshold");
`endif

endmodule

// ===== bench/bhse_setpoint_checker.sv =====
// ----------------------------------------------------------------------------
// bhse_setpoint_checker
// Watches the tick, result and register channels of the setpoint editor,
// keeps its own copy of the editor state and limits, and compares every
// result transfer with the setpoints predicted for the oldest pending tick.
// ----------------------------------------------------------------------------
module bhse_setpoint_checker
   import bhse_pkg::*;
#(
   parameter int unsigned HOLD_TICKS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata,
   output int          mismatch_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   cfg_type   limits;
   state_type editor;
   rsp_type   expected_setpoints[$];
   rsp_type   want;
   int        result_number;

   // Saturating hold counter that clears on release.
   function automatic logic [2:0] hold_tick(input logic [2:0] cnt, input logic pressed);
      if (!pressed) return 3'd0;
      return (cnt == CNT_TOP) ? CNT_TOP : cnt + 3'd1;
   endfunction

   // Advance the editor copy by one poll tick and return the setpoints after it.
   function automatic rsp_type next_setpoints(input req_type t);
      int unsigned volt;
      int unsigned amps;
      logic        l;
      logic        r;
      rsp_type     res;
      l = t.left_pressed;
      r = t.right_pressed;
      editor.right_cnt = hold_tick(editor.right_cnt, r);
      editor.left_cnt  = hold_tick(editor.left_cnt, l);
      volt = editor.voltage;
      amps = editor.current;

      // Steps use the mode as it stood before any toggle in this tick.
      if (!editor.mode) begin
         if (r && editor.right_cnt > HOLD_TICKS && volt < limits.max_voltage_mv)
            volt = (volt + V_STEP > V_TOP) ? V_TOP : volt + V_STEP;
         if (l && editor.left_cnt > HOLD_TICKS && volt > limits.min_voltage_mv)
            volt = (volt < V_STEP) ? 0 : volt - V_STEP;
      end else begin
         if (r && editor.right_cnt > HOLD_TICKS && amps < limits.max_current_ma)
            amps = (amps + I_STEP > I_TOP) ? I_TOP : amps + I_STEP;
         if (l && editor.left_cnt > HOLD_TICKS && amps > 0)
            amps = (amps < I_STEP) ? 0 : amps - I_STEP;
      end
      editor.voltage = volt[14:0];
      editor.current = amps[12:0];

      // Holding both buttons toggles the edit mode and restarts its count.
      editor.both_cnt = hold_tick(editor.both_cnt, l && r);
      if (editor.both_cnt > HOLD_TICKS) begin
         editor.mode     = ~editor.mode;
         editor.both_cnt = 3'd0;
      end

      // Holding middle toggles the output enable the same way.
      editor.middle_cnt = hold_tick(editor.middle_cnt, t.middle_pressed);
      if (editor.middle_cnt > HOLD_TICKS) begin
         editor.output_on  = ~editor.output_on;
         editor.middle_cnt = 3'd0;
      end

      res.voltage_setpoint_mv = editor.voltage;
      res.current_setpoint_ma = editor.current;
      res.edit_mode           = editor.mode;
      res.output_on           = editor.output_on;
      return res;
   endfunction

   // Sample all three channels at the clock edge that completes a transfer.
   always @(posedge clock) begin
      if (reset) begin
         limits.min_voltage_mv = MIN_V_RESET;
         limits.max_voltage_mv = MAX_V_RESET;
         limits.max_current_ma = MAX_I_RESET;
         editor                = '0;
         editor.voltage        = V_RESET;
         editor.current        = I_RESET;
         expected_setpoints.delete();
         mismatch_count        = 0;
         result_number         = 0;
      end else begin
         // Register writes; an index past the last register is dropped.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MIN_VOLTAGE: limits.min_voltage_mv = csr_wdata;
               CSR_MAX_VOLTAGE: limits.max_voltage_mv = csr_wdata;
               CSR_MAX_CURRENT: limits.max_current_ma = csr_wdata[12:0];
               default: ;
            endcase
         end

         // Compare a result transfer with the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            if (expected_setpoints.size() == 0) begin
               if (mismatch_count < 10)
                  $display("result %0d arrived with no tick pending: %0d mV %0d mA mode %0b out %0b",
                           result_number, rsp_data.voltage_setpoint_mv,
                           rsp_data.current_setpoint_ma, rsp_data.edit_mode,
                           rsp_data.output_on);
               mismatch_count++;
            end else begin
               want = expected_setpoints.pop_front();
               if (rsp_data.voltage_setpoint_mv !== want.voltage_setpoint_mv ||
                   rsp_data.current_setpoint_ma !== want.current_setpoint_ma ||
                   rsp_data.edit_mode !== want.edit_mode ||
                   rsp_data.output_on !== want.output_on) begin
                  if (mismatch_count < 10)
                     $display("result %0d: exp %0d mV %0d mA mode %0b out %0b, got %0d mV %0d mA mode %0b out %0b",
                              result_number, want.voltage_setpoint_mv,
                              want.current_setpoint_ma, want.edit_mode, want.output_on,
                              rsp_data.voltage_setpoint_mv, rsp_data.current_setpoint_ma,
                              rsp_data.edit_mode, rsp_data.output_on);
                  mismatch_count++;
               end
            end
            result_number++;
         end

         // Each accepted tick produces exactly one result.
         if (req_valid && !req_stall)
            expected_setpoints.push_back(next_setpoints(req_data));
      end
      pending_count <= expected_setpoints.size();
   end

endmodule

// ===== bench/button_hold_setpoint_editor_unit_test.sv =====
// ----------------------------------------------------------------------------
// button_hold_setpoint_editor_unit_test
// Drives poll ticks of button levels and limit register writes into the
// setpoint editor under random gaps and result stalls. Long holds sweep the
// setpoints to their saturation points; the checker beside the block does
// the prediction and comparison.
// ----------------------------------------------------------------------------
module button_hold_setpoint_editor_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import bhse_pkg::*;

   localparam int unsigned HOLD_TICKS   = 5;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          CYCLE_LIMIT  = 500000;
   localparam logic [1:0]  CSR_UNUSED   = 2'd3;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_MIN_VOLTAGE;
   logic [14:0] csr_wdata = '0;
   int          mismatch_count;
   int          pending_count;

   int          cycle_count = 0;
   int          stall_hold  = 0;
   int          stall_pick;
   int          burst_left  = 0;
   int          combo;
   logic        seen_mode    = 1'b0;
   logic [14:0] seen_voltage = V_RESET;
   logic [12:0] seen_current = I_RESET;

   button_hold_setpoint_editor_unit #(.HOLD_TICKS(HOLD_TICKS)) dut (.*);

   bhse_setpoint_checker #(.HOLD_TICKS(HOLD_TICKS)) u_checker (.*);

   always #2 clock = ~clock;

   // Abort a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Result stalls: free stretches, short random stalls and a few long ones.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 50) begin
            rsp_stall  <= 1'b0;
            stall_hold <= $urandom_range(0, 20);
         end else if (stall_pick < 88) begin
            rsp_stall  <= 1'b1;
            stall_hold <= $urandom_range(0, 2);
         end else begin
            rsp_stall  <= 1'b1;
            stall_hold <= $urandom_range(10, 40);
         end
      end
   end

   // Last setpoints seen on the result channel, used to steer the sweeps.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         seen_mode    <= rsp_data.edit_mode;
         seen_voltage <= rsp_data.voltage_setpoint_mv;
         seen_current <= rsp_data.current_setpoint_ma;
      end
   end

   function automatic req_type buttons(input logic left, input logic right,
                                       input logic middle);
      req_type t;
      t.left_pressed   = left;
      t.right_pressed  = right;
      t.middle_pressed = middle;
      return t;
   endfunction

   // One tick transfer after a random gap; valid stays high for the next call.
   task automatic send_tick(input req_type t);
      int gap;
      int roll;
      roll = $urandom_range(0, 99);
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else if (roll < 3) begin
         burst_left = $urandom_range(20, 60);
         gap = 0;
      end else if (roll < 60) begin
         gap = 0;
      end else if (roll < 92) begin
         gap = $urandom_range(1, 3);
      end else begin
         gap = $urandom_range(8, 30);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic hold(input req_type t, input int n);
      repeat (n) send_tick(t);
   endtask

   // Stop sending and wait until every pending result has come out.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write transfer; valid is left high for a following write.
   task automatic csr_write(input logic [1:0] index, input logic [14:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Load all limits while idle, plus a write to the unused index.
   task automatic set_limits(input logic [14:0] min_mv, input logic [14:0] max_mv,
                             input logic [14:0] max_ma);
      settle();
      csr_write(CSR_MIN_VOLTAGE, min_mv);
      csr_write(CSR_MAX_VOLTAGE, max_mv);
      csr_write(CSR_MAX_CURRENT, max_ma);
      csr_write(CSR_UNUSED, 15'($urandom_range(0, 32767)));
      csr_valid <= 1'b0;
   endtask

   // Long holds in one direction until the chosen setpoint saturates.
   task automatic sweep(input logic want_mode, input logic go_up);
      int   tries;
      logic done;
      settle();
      for (tries = 0; tries < 4 && seen_mode != want_mode; tries++) begin
         send_tick(buttons(1'b0, 1'b0, 1'b0));
         hold(buttons(1'b1, 1'b1, 1'b0), 6);
         send_tick(buttons(1'b0, 1'b0, 1'b0));
         settle();
      end
      done = 1'b0;
      for (tries = 0; tries < 40 && !done; tries++) begin
         hold(buttons(!go_up, go_up, 1'b0), $urandom_range(30, 70));
         send_tick(buttons(1'b0, 1'b0, 1'b0));
         settle();
         if (want_mode)
            done = go_up ? (seen_current == I_TOP) : (seen_current == '0);
         else
            done = go_up ? (seen_voltage == V_TOP) : (seen_voltage == '0);
      end
   endtask

   // Mostly button holds of random length, some noise ticks and idle pauses.
   task automatic random_phase(input int n);
      int      sent;
      int      kind;
      int      len;
      req_type t;
      sent = 0;
      while (sent < n) begin
         kind = $urandom_range(0, 99);
         if (kind < 80) begin
            case ($urandom_range(0, 6))
               0: t = buttons(1'b0, 1'b1, 1'b0);
               1: t = buttons(1'b1, 1'b0, 1'b0);
               2: t = buttons(1'b1, 1'b1, 1'b0);
               3: t = buttons(1'b0, 1'b0, 1'b1);
               4: t = buttons(1'b0, 1'b1, 1'b1);
               5: t = buttons(1'b1, 1'b0, 1'b1);
               default: t = buttons(1'b1, 1'b1, 1'b1);
            endcase
            len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 9) : $urandom_range(10, 30);
            hold(t, len);
            send_tick(buttons(1'b0, 1'b0, 1'b0));
            sent += len + 1;
         end else if (kind < 97) begin
            len = $urandom_range(1, 4);
            repeat (len) send_tick(req_type'(3'($urandom_range(0, 7))));
            sent += len;
         end else begin
            settle();
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks at reset limits: every button combination, a right
      // hold past the counter top, a both hold that toggles the mode while
      // stepping in the old mode, and a middle hold that toggles the output.
      for (combo = 0; combo < 8; combo++)
         send_tick(req_type'(3'(combo)));
      hold(buttons(1'b0, 1'b1, 1'b0), 8);
      hold(buttons(1'b1, 1'b1, 1'b0), 6);
      hold(buttons(1'b0, 1'b0, 1'b1), 6);

      // Widest limits: drive the voltage down to zero and the current up
      // into saturation.
      set_limits(15'd0, V_TOP, V_TOP);
      sweep(1'b0, 1'b0);
      sweep(1'b1, 1'b1);
      random_phase(50);

      // Pinned voltage window and a zero current limit.
      set_limits(15'd5000, 15'd5000, 15'd0);
      random_phase(40);

      // Minimum above maximum.
      set_limits(15'd20000, 15'd1000, 15'd6350);
      random_phase(40);

      // Reset values, with upper data bits set on the current limit.
      set_limits(MIN_V_RESET, MAX_V_RESET, {2'b11, MAX_I_RESET});
      random_phase(40);

      repeat (2) begin
         set_limits(15'($urandom_range(0, 25500)), 15'($urandom_range(0, 25500)),
                    15'($urandom_range(0, 32767)));
         random_phase(30);
      end

      settle();
      if (mismatch_count == 0 && pending_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/bhse_pkg.sv
design/bhse_update.sv
design/button_hold_setpoint_editor_unit.sv
bench/bhse_setpoint_checker.sv
bench/button_hold_setpoint_editor_unit_test.sv
